@@ rtl/cubic_bezier_easing_assert.svh @@
// ----------------------------------------------------------------------------
// cubic_bezier_easing_assert.svh
// assertion macros for the cubic bezier easing block, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_ASSERT_SVH
`define CUBIC_BEZIER_EASING_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication on clk, held off during reset
`define CBE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, held off during reset
`define CBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CBE_ASSERT_IMPL(label, ante, cons, msg)
`define CBE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg
// shared types and constants of the cubic bezier easing block
// ----------------------------------------------------------------------------
`default_nettype none

package cbe_pkg;

    // default configuration of the pipeline
    localparam int BISECT_STEPS_DEFAULT = 24;
    localparam int FRAC_BITS_DEFAULT    = 16;

    // field widths
    localparam int WX        = 17;
    localparam int WY        = 19;
    localparam int WP        = 19;
    localparam int CFG_IDX_W = 2;

    // register reset values: 0.3, 1.3, 0.3, 1.0
    localparam logic [WX-1:0] CTRL1_X_RST = 17'd19661;
    localparam logic [WY-1:0] CTRL1_Y_RST = 19'd85197;
    localparam logic [WX-1:0] CTRL2_X_RST = 17'd19661;
    localparam logic [WY-1:0] CTRL2_Y_RST = 19'd65536;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CTRL1_X = 2'd0,
        REG_CTRL1_Y = 2'd1,
        REG_CTRL2_X = 2'd2,
        REG_CTRL2_Y = 2'd3
    } cfg_reg_t;

    // bernstein weights, unsigned q.30 (w1, w2 already scaled by three)
    typedef struct packed {
        logic [31:0] w1;
        logic [31:0] w2;
        logic [29:0] w3;
    } cbe_weights_t;

    // hand-off between neighboring bisection cells
    typedef struct packed {
        logic          valid;
        logic [31:0]   lo;     // lower bisection bound, q.32
        logic [WP-1:0] t;      // clamped progress
    } cbe_link_t;

    // result leaving the curve evaluation cell
    typedef struct packed {
        logic          valid;
        logic [WY-1:0] value;
    } cbe_result_t;

endpackage

`default_nettype wire

@@ rtl/cbe_weights.sv @@
// ----------------------------------------------------------------------------
// cbe_weights
// two-stage pipeline computing the cubic bernstein weights of a q.32 parameter
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_weights
    import cbe_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  logic [31:0]  s,
    output cbe_weights_t w
);

    logic [29:0] p;
    logic [30:0] q;
    logic [59:0] pp_full;
    logic [61:0] qq_full;

    logic [29:0] p_reg;
    logic [30:0] q_reg;
    logic [29:0] pp_reg;
    logic [30:0] qq_reg;

    logic [60:0] a_full;
    logic [60:0] b_full;
    logic [59:0] c_full;
    logic [29:0] a;
    logic [29:0] b;

    logic [31:0] w1_reg;
    logic [31:0] w2_reg;
    logic [29:0] w3_reg;

    // stage 1: p = s in q.30, q = 1 - p, squares
    assign p       = s[31:2];
    assign q       = (31'd1 << 30) - {1'b0, p};
    assign pp_full = 60'(p) * 60'(p);
    assign qq_full = 62'(q) * 62'(q);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= p;
            q_reg  <= q;
            pp_reg <= pp_full[59:30];
            qq_reg <= qq_full[60:30];
        end
    end

    // stage 2: cubic terms, scale the mixed terms by three
    assign a_full = 61'(qq_reg) * 61'(p_reg);
    assign b_full = 61'(pp_reg) * 61'(q_reg);
    assign c_full = 60'(pp_reg) * 60'(p_reg);
    assign a      = a_full[59:30];
    assign b      = b_full[59:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= {1'b0, a, 1'b0} + {2'b00, a};
            w2_reg <= {1'b0, b, 1'b0} + {2'b00, b};
            w3_reg <= c_full[59:30];
        end
    end

    assign w = '{w1: w1_reg, w2: w2_reg, w3: w3_reg};

endmodule

`default_nettype wire

@@ rtl/cbe_bisect_cell.sv @@
// ----------------------------------------------------------------------------
// cbe_bisect_cell
// one bisection step on x(s): four pipeline stages, one bound bit decided
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_bisect_cell
    import cbe_pkg::*;
#(
    parameter int STEP      = 0,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [WX-1:0] ctrl1_x,
    input  logic [WX-1:0] ctrl2_x,
    input  cbe_link_t     link_in,
    output cbe_link_t     link_out
);

    // half width of the interval at this step, q.32
    localparam logic [31:0] HALF = 32'((64'd1 << 32) >> (STEP + 1));
    localparam int PW = 32 + WX;
    localparam int XW = ((PW > 31 + FRAC_BITS) ? PW : 31 + FRAC_BITS) + 2;

    logic [31:0]   mid;
    cbe_weights_t  w;

    logic [2:0]    vld_reg;
    logic [31:0]   mid_reg [3];
    logic [WP-1:0] t_reg   [3];

    logic [PW-1:0] prod1_reg;
    logic [PW-1:0] prod2_reg;
    logic [29:0]   w3_reg;

    logic [XW-1:0] xv;
    logic [XW-1:0] tq;
    logic [31:0]   lo_old;

    logic          out_valid_reg;
    logic [31:0]   out_lo_reg;
    logic [WP-1:0] out_t_reg;

    // midpoint of the current interval
    assign mid = link_in.lo + HALF;

    cbe_weights u_weights (
        .clk (clk),
        .en  (en),
        .s   (mid),
        .w   (w)
    );

    // valid travels beside the weight pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[1:0], link_in.valid};
            out_valid_reg <= vld_reg[2];
        end
    end

    // sideband delay line: midpoint and progress
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg[0] <= mid;
            mid_reg[1] <= mid_reg[0];
            mid_reg[2] <= mid_reg[1];
            t_reg[0]   <= link_in.t;
            t_reg[1]   <= t_reg[0];
            t_reg[2]   <= t_reg[1];
        end
    end

    // stage 3: weight times control x
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= PW'(w.w1) * PW'(ctrl1_x);
            prod2_reg <= PW'(w.w2) * PW'(ctrl2_x);
            w3_reg    <= w.w3;
        end
    end

    // stage 4: x(mid) against progress, move one bound
    assign xv     = XW'(prod1_reg) + XW'(prod2_reg) + (XW'(w3_reg) << FRAC_BITS);
    assign tq     = XW'(t_reg[2]) << 30;
    assign lo_old = mid_reg[2] - HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_lo_reg <= (xv < tq) ? mid_reg[2] : lo_old;
            out_t_reg  <= t_reg[2];
        end
    end

    assign link_out = '{valid: out_valid_reg, lo: out_lo_reg, t: out_t_reg};

endmodule

`default_nettype wire

@@ rtl/cbe_eval_y.sv @@
// ----------------------------------------------------------------------------
// cbe_eval_y
// y(s) at the final midpoint: weights, products, rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_eval_y
    import cbe_pkg::*;
#(
    parameter int BISECT_STEPS = BISECT_STEPS_DEFAULT,
    parameter int FRAC_BITS    = FRAC_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [WY-1:0] ctrl1_y,
    input  logic [WY-1:0] ctrl2_y,
    input  cbe_link_t     link_in,
    output cbe_result_t   result
);

    // half width of the last interval, zero once the bound is exact
    localparam logic [31:0] FIN_HALF = 32'((64'd1 << 32) >> (BISECT_STEPS + 1));
    localparam int PW = 33 + WY;
    localparam int YW = ((PW > 32 + FRAC_BITS) ? PW : 32 + FRAC_BITS) + 2;
    localparam int RW = YW - 30;
    localparam logic [YW-1:0] ROUND = YW'(1) << 29;
    localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (WY - 1)) - 64'd1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    logic [31:0]            mid;
    cbe_weights_t           w;

    logic [3:0]             vld_reg;
    logic signed [PW-1:0]   p1_reg;
    logic signed [PW-1:0]   p2_reg;
    logic [29:0]            w3_reg;
    logic signed [YW-1:0]   ysum;
    logic signed [RW-1:0]   rnd_reg;

    logic                   out_valid_reg;
    logic [WY-1:0]          out_value_reg;

    // final midpoint
    assign mid = link_in.lo + FIN_HALF;

    cbe_weights u_weights (
        .clk (clk),
        .en  (en),
        .s   (mid),
        .w   (w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[2:0], link_in.valid};
            out_valid_reg <= vld_reg[3];
        end
    end

    // stage 3: signed products with control y
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= $signed({1'b0, w.w1}) * $signed(ctrl1_y);
            p2_reg <= $signed({1'b0, w.w2}) * $signed(ctrl2_y);
            w3_reg <= w.w3;
        end
    end

    // stage 4: sum, round half up to q.f
    assign ysum = YW'(p1_reg) + YW'(p2_reg) + $signed(YW'(w3_reg) << FRAC_BITS)
                + $signed(ROUND);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg <= ysum[YW-1:30];
        end
    end

    // stage 5: saturate to the output range
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rnd_reg > SAT_HI)
            begin
                out_value_reg <= WY'(SAT_HI);
            end
            else if (rnd_reg < SAT_LO)
            begin
                out_value_reg <= WY'(SAT_LO);
            end
            else
            begin
                out_value_reg <= WY'(rnd_reg);
            end
        end
    end

    assign result = '{valid: out_valid_reg, value: out_value_reg};

endmodule

`default_nettype wire

@@ rtl/cubic_bezier_easing.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_easing
// css-style cubic bezier easing: progress in, eased curve value out
// ----------------------------------------------------------------------------
// Takes one progress sample per cycle and returns one eased value for each,
// in order. Progress is clamped to zero..one, then a row of BISECT_STEPS
// bisection cells, four pipeline stages each, searches the curve parameter
// on x(s); a five-stage evaluation cell computes y at the final midpoint,
// rounds it and saturates it. The pipeline and a two-entry output buffer let
// the block keep accepting while results wait; it stalls only when both
// buffer entries are full and a result is ready to leave the pipeline. The
// user must write control points through cfg_we/cfg_index/cfg_data only
// while no sample is in flight; the block itself does not enforce this.
`default_nettype none

`include "cubic_bezier_easing_assert.svh"

module cubic_bezier_easing
    import cbe_pkg::*;
#(
    parameter int BISECT_STEPS = BISECT_STEPS_DEFAULT,
    parameter int FRAC_BITS    = FRAC_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WY-1:0]        cfg_data,

    input  logic                 progress_valid,
    output logic                 progress_ready,
    input  logic [WP-1:0]        progress,

    output logic                 eased_valid,
    input  logic                 eased_ready,
    output logic [WY-1:0]        eased
);

    localparam int CW = ((FRAC_BITS + 2) > WP) ? FRAC_BITS + 2 : WP;
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    logic [WX-1:0] ctrl1_x_reg;
    logic [WY-1:0] ctrl1_y_reg;
    logic [WX-1:0] ctrl2_x_reg;
    logic [WY-1:0] ctrl2_y_reg;

    logic          pipe_en;
    logic [WP-1:0] t_clamp;
    logic          in_valid_reg;
    logic [WP-1:0] in_t_reg;
    cbe_link_t     link [BISECT_STEPS+1];
    cbe_result_t   yres;

    logic          eased_valid_reg;
    logic [WY-1:0] eased_reg;
    logic          skid_valid_reg;
    logic [WY-1:0] skid_reg;
    logic          push;
    logic          pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_x_reg <= CTRL1_X_RST;
            ctrl1_y_reg <= CTRL1_Y_RST;
            ctrl2_x_reg <= CTRL2_X_RST;
            ctrl2_y_reg <= CTRL2_Y_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CTRL1_X: ctrl1_x_reg <= cfg_data[WX-1:0];
                REG_CTRL1_Y: ctrl1_y_reg <= cfg_data;
                REG_CTRL2_X: ctrl2_x_reg <= cfg_data[WX-1:0];
                REG_CTRL2_Y: ctrl2_y_reg <= cfg_data;
            endcase
        end
    end

    // pipeline moves unless a result is ready and the buffer is full
    assign pipe_en        = !(yres.valid && eased_valid_reg && skid_valid_reg);
    assign progress_ready = pipe_en;

    // clamp progress to zero..one
    always_comb
    begin
        if (progress[WP-1])
        begin
            t_clamp = '0;
        end
        else if (CW'(progress) > ONE)
        begin
            t_clamp = WP'(ONE);
        end
        else
        begin
            t_clamp = progress;
        end
    end

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            in_valid_reg <= progress_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            in_t_reg <= t_clamp;
        end
    end

    assign link[0] = '{valid: in_valid_reg, lo: 32'd0, t: in_t_reg};

    // row of bisection cells
    for (genvar i = 0; i < BISECT_STEPS; i++)
    begin : g_cell
        cbe_bisect_cell #(
            .STEP      (i),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (pipe_en),
            .ctrl1_x  (ctrl1_x_reg),
            .ctrl2_x  (ctrl2_x_reg),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

    // curve value at the final midpoint
    cbe_eval_y #(
        .BISECT_STEPS (BISECT_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_eval_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .ctrl1_y (ctrl1_y_reg),
        .ctrl2_y (ctrl2_y_reg),
        .link_in (link[BISECT_STEPS]),
        .result  (yres)
    );

    // two-entry output buffer: head register plus skid
    assign push = pipe_en && yres.valid;
    assign pop  = eased_valid_reg && eased_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eased_valid_reg <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            priority if (pop)
            begin
                eased_valid_reg <= skid_valid_reg || push;
                skid_valid_reg  <= skid_valid_reg && push;
            end
            else if (!eased_valid_reg)
            begin
                eased_valid_reg <= push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (pop)
        begin
            eased_reg <= skid_valid_reg ? skid_reg : yres.value;
            skid_reg  <= yres.value;
        end
        else if (!eased_valid_reg)
        begin
            eased_reg <= yres.value;
        end
        else if (push && !skid_valid_reg)
        begin
            skid_reg <= yres.value;
        end
    end

    assign eased_valid = eased_valid_reg;
    assign eased       = eased_reg;

    // buffer never holds a skid entry behind an empty head
    `CBE_ASSERT_IMPL(a_skid_behind_head, skid_valid_reg, eased_valid_reg, "skid without head")

    // a transfer out of a full buffer leaves the head filled
    `CBE_ASSERT_NEXT(a_pop_refills, pop && skid_valid_reg, eased_valid_reg, "head lost on pop")

    // a stalled result stays at the pipeline end
    `CBE_ASSERT_NEXT(a_stall_keeps, yres.valid && !pipe_en, yres.valid, "stalled result lost")

endmodule

`default_nettype wire
